### src/rc4_pkg.sv
// Shared types, constants and helpers for the RC4 stream cipher block.
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_W         = MAX_KEY_BYTES * 8;
  localparam int KEY_LEN_W     = 5;
  localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
  localparam int BYTE_W        = 8;
  localparam int SBOX_DEPTH    = 256;
  localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic [SBOX_AW-1:0] SBOX_LAST = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J,
    ST_EMIT
  } rc4_state_t;

  // Key as seen by the sequencer; len is already saturated
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] len;
  } key_cfg_t;

  // Sequencer status, for checks at the top level
  typedef struct packed {
    rc4_state_t state;
    logic       keyed;
  } core_status_t;

  // Byte idx of the key
  function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                 input logic [KIDX_W-1:0] idx);
    return key[{idx, 3'b000} +: BYTE_W];
  endfunction

endpackage

### src/rc4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rc4_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/rc4_cfg.sv
// Key registers and key length saturation.
module rc4_cfg import rc4_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output key_cfg_t              key_cfg
);

  logic [CFG_DATA_W-1:0] key_low;
  logic [CFG_DATA_W-1:0] key_high;
  logic [KEY_LEN_W-1:0]  key_length;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_KEY_HIGH:   key_high   <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate length to the supported key size
  always_comb begin
    key_cfg.key = {key_high, key_low};
    if (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_cfg.len = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_cfg.len = key_length;
    end
  end

endmodule

### src/rc4_core.sv
// Sequencer: key schedule and keystream generation over the permutation RAM.
module rc4_core import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  key_cfg_t          key_cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data,
  input  logic              in_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_data,
  output core_status_t      status
);

  rc4_state_t state, state_next;

  logic [SBOX_AW-1:0] n;
  logic [KIDX_W-1:0]  kidx;
  logic [SBOX_AW-1:0] i;
  logic [SBOX_AW-1:0] j;
  logic [BYTE_W-1:0]  si;
  logic [BYTE_W-1:0]  sj;
  logic [SBOX_AW-1:0] t;
  logic [BYTE_W-1:0]  ks;
  logic [BYTE_W-1:0]  data;
  logic               start;
  logic               keyed;

  logic               ram_we;
  logic [SBOX_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [SBOX_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic [SBOX_AW-1:0] j_ks;
  logic [SBOX_AW-1:0] j_gen;
  logic [SBOX_AW-1:0] t_gen;
  logic [BYTE_W-1:0]  ks_fwd;
  logic               accept;
  logic               emit;

  rc4_ram #(
    .ADDR_W (SBOX_AW),
    .DATA_W (BYTE_W)
  ) u_sbox (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == ST_EMIT) && (!out_valid || out_ready);

  // Index arithmetic, all mod 256
  assign j_ks  = j + ram_rdata + key_byte(key_cfg.key, kidx);
  assign j_gen = j + ram_rdata;
  assign t_gen = si + ram_rdata;

  // Swap has not landed in the RAM yet when S[t] is read
  always_comb begin
    if (t == j) begin
      ks_fwd = si;
    end else if (t == i) begin
      ks_fwd = sj;
    end else begin
      ks_fwd = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (key_cfg.len == '0) begin
            state_next = ST_EMIT;
          end else if (in_start || !keyed) begin
            state_next = ST_INIT;
          end else begin
            state_next = ST_GEN_RD_I;
          end
        end
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = n;
        ram_wdata = n;
        if (n == SBOX_LAST) begin
          state_next = ST_KS_RD_I;
        end
      end
      ST_KS_RD_I: begin
        ram_raddr  = n;
        state_next = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        ram_raddr  = j_ks;
        state_next = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        ram_we     = 1'b1;
        ram_waddr  = n;
        ram_wdata  = ram_rdata;
        state_next = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = si;
        if (n == SBOX_LAST) begin
          state_next = ST_GEN_RD_I;
        end else begin
          state_next = ST_KS_RD_I;
        end
      end
      ST_GEN_RD_I: begin
        ram_raddr  = i + 1'b1;
        state_next = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        ram_raddr  = j_gen;
        state_next = ST_GEN_WR_I;
      end
      ST_GEN_WR_I: begin
        ram_we     = 1'b1;
        ram_waddr  = i;
        ram_wdata  = ram_rdata;
        ram_raddr  = t_gen;
        state_next = ST_GEN_WR_J;
      end
      ST_GEN_WR_J: begin
        ram_we     = 1'b1;
        ram_waddr  = j;
        ram_wdata  = si;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: indices and keyed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      j     <= '0;
      n     <= '0;
      kidx  <= '0;
      keyed <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            n    <= '0;
            kidx <= '0;
            if (key_cfg.len != '0 && (in_start || !keyed)) begin
              j <= '0;
            end
          end
        end
        ST_INIT: begin
          n <= n + 1'b1;
        end
        ST_KS_RD_J: begin
          j <= j_ks;
          if ({1'b0, kidx} == key_cfg.len - 1'b1) begin
            kidx <= '0;
          end else begin
            kidx <= kidx + 1'b1;
          end
        end
        ST_KS_WR_J: begin
          n <= n + 1'b1;
          if (n == SBOX_LAST) begin
            i     <= '0;
            j     <= '0;
            keyed <= 1'b1;
          end
        end
        ST_GEN_RD_I: begin
          i <= i + 1'b1;
        end
        ST_GEN_RD_J: begin
          j <= j_gen;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      data  <= in_data;
      start <= in_start;
      ks    <= '0;
    end
    case (state)
      ST_KS_RD_J:  si <= ram_rdata;
      ST_GEN_RD_J: si <= ram_rdata;
      ST_GEN_WR_I: begin
        sj <= ram_rdata;
        t  <= t_gen;
      end
      ST_GEN_WR_J: ks <= ks_fwd;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= data ^ ks;
    end
  end

  assign status.state = state;
  assign status.keyed = keyed || start;

endmodule

### src/rc4_stream_cipher_top.sv
// RC4 stream cipher: top level with key registers and the keystream sequencer.
//
//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: data_byte, tuser: message_start
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: result_byte
//  cfg      | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// A keyed byte passes through accept, four RAM steps of the generator (read S[i],
// read S[j], two swap writes over the single write port), and the output load.
// A byte with an empty key goes from accept straight to the output load. A key schedule
// first fills all 256 entries of the permutation, then does the keyed swap for each entry.
// Reset is synchronous; the permutation RAM is not cleared, the schedule fills it.
// A full output register holds the sequencer in its last step; one item is in work at a time.
module rc4_stream_cipher_top import rc4_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] message_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] result_byte
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  key_cfg_t     key_cfg;
  core_status_t status;

  rc4_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_cfg   (key_cfg)
  );

  rc4_core u_core (
    .clk       (clk),
    .rst       (rst),
    .key_cfg   (key_cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // A started message with a key goes straight into the permutation fill
  a_start_schedules: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && key_cfg.len != '0)
    |=> (status.state == ST_INIT))
    else $error("message start did not run the key schedule");

  // An empty key bypasses the permutation entirely
  a_empty_key_bypass: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && key_cfg.len == '0)
    |=> (status.state == ST_EMIT))
    else $error("empty key did not pass the byte through");

  // The generator never runs on an unscheduled permutation
  a_gen_keyed: assert property (@(posedge clk) disable iff (rst)
    (status.state == ST_GEN_RD_I) |-> status.keyed)
    else $error("keystream step before key schedule");

  // A pending result is not dropped
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");
`endif

endmodule
